FILE: hw/rtl/lmbf_pkg.sv
// ----------------------------------------------------------------------------
// lmbf_pkg
// Shared constants, types and gamma tables for the LED matrix bit-plane
// frame buffer.
// ----------------------------------------------------------------------------
package lmbf_pkg;

   // Default geometry of the matrix.
   localparam int ROWS_DEFAULT    = 7;
   localparam int PLANES_DEFAULT  = 15;
   localparam int COLUMNS_DEFAULT = 16;

   // Request kinds.
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FETCH = 1'b1;

   // Field widths.
   localparam int COORD_W  = 8;
   localparam int COLOR_W  = 8;
   localparam int ROW_W    = 3;
   localparam int COL_W    = 4;
   localparam int WORD_W   = 32;
   localparam int NIBBLES  = WORD_W / 4;
   localparam int NIB_SEL_W = 3;

   // Each frame is three stream words: two pixel words and one control word.
   localparam int PIX_WORDS   = 2;
   localparam int FRAME_WORDS = 3;

   localparam logic [7:0]  DISCHARGE_SELECT = 8'h7F;
   localparam logic [15:0] DISCHARGE_TICKS  = 16'hFFFF;

   // Gamma tables: 256 entries of 14 bits, packed with entry v at bits v*14.
   localparam int GAMMA_W        = 14;
   localparam int GAMMA_ENTRIES  = 256;
   localparam int GAMMA_ROM_BITS = GAMMA_ENTRIES * GAMMA_W;
   localparam int GAMMA_MAX      = 16383;
   localparam int GAMMA_SCALE2   = 2 * GAMMA_MAX;
   localparam int COLOR_MAX      = 255;
   localparam int WIDE_W         = 256;

   // Write port of the plane memory; the address travels beside it.
   typedef struct packed {
      logic                 en;
      logic [NIBBLES-1:0]   nib_en;
      logic [WORD_W-1:0]    data;
   } wr_port_type;

   // Entry v is round(16383 * (v/255)^(p/q)) with halves rounded up. The
   // search compares (2m-1)^q * 255^p against 32766^q * v^p exactly.
   function automatic logic [GAMMA_ROM_BITS-1:0] build_gamma(input int p, input int q);
      logic [GAMMA_ROM_BITS-1:0] rom;
      logic [WIDE_W-1:0]         rhs;
      logic [WIDE_W-1:0]         lhs;
      int                        v;
      int                        t;
      int                        lo;
      int                        hi;
      int                        mid;
      rom = '0;
      for (v = 0; v < GAMMA_ENTRIES; v++) begin
         rhs = WIDE_W'(1);
         for (t = 0; t < q; t++) rhs = rhs * WIDE_W'(GAMMA_SCALE2);
         for (t = 0; t < p; t++) rhs = rhs * WIDE_W'(v);
         lo = 0;
         hi = GAMMA_MAX;
         while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            lhs = WIDE_W'(1);
            for (t = 0; t < q; t++) lhs = lhs * WIDE_W'(2 * mid - 1);
            for (t = 0; t < p; t++) lhs = lhs * WIDE_W'(COLOR_MAX);
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
         end
         rom[v*GAMMA_W +: GAMMA_W] = GAMMA_W'(lo);
      end
      return rom;
   endfunction

   localparam logic [GAMMA_ROM_BITS-1:0] RED_GAMMA_ROM   = build_gamma(14, 5);
   localparam logic [GAMMA_ROM_BITS-1:0] GREEN_GAMMA_ROM = build_gamma(7, 2);
   localparam logic [GAMMA_ROM_BITS-1:0] BLUE_GAMMA_ROM  = build_gamma(13, 5);

endpackage

FILE: hw/rtl/lmbf_plane_ram.sv
// ----------------------------------------------------------------------------
// lmbf_plane_ram
// Bit-plane pixel store: 32-bit words, nibble write enables, one registered
// read port.
// ----------------------------------------------------------------------------
module lmbf_plane_ram #(
   parameter int DEPTH  = 210,
   parameter int ADDR_W = 8
) (
   input  logic                              clock,
   input  logic [ADDR_W-1:0]                 wr_addr,
   input  lmbf_pkg::wr_port_type             wr,
   input  logic                              rd_en,
   input  logic [ADDR_W-1:0]                 rd_addr,
   output logic [lmbf_pkg::WORD_W-1:0]       rd_data
);

   logic [lmbf_pkg::WORD_W-1:0] plane_mem_ff [DEPTH];
   logic [lmbf_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      for (int n = 0; n < lmbf_pkg::NIBBLES; n++) begin
         if (wr.en && wr.nib_en[n]) begin
            plane_mem_ff[wr_addr][n*4 +: 4] <= wr.data[n*4 +: 4];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= plane_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/lmbf_pixel_writer.sv
// ----------------------------------------------------------------------------
// lmbf_pixel_writer
// Gamma-corrects a pixel and shifts its color bits out one plane per cycle
// into the plane memory. Also runs the clearing pass after reset.
// ----------------------------------------------------------------------------
module lmbf_pixel_writer #(
   parameter int ROWS    = lmbf_pkg::ROWS_DEFAULT,
   parameter int PLANES  = lmbf_pkg::PLANES_DEFAULT,
   parameter int COLUMNS = lmbf_pkg::COLUMNS_DEFAULT,
   parameter int ADDR_W  = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [lmbf_pkg::COORD_W-1:0]      x,
   input  logic [lmbf_pkg::COORD_W-1:0]      y,
   input  logic [lmbf_pkg::COLOR_W-1:0]      red,
   input  logic [lmbf_pkg::COLOR_W-1:0]      green,
   input  logic [lmbf_pkg::COLOR_W-1:0]      blue,
   output logic                              busy,
   output logic [ADDR_W-1:0]                 wr_addr,
   output lmbf_pkg::wr_port_type             wr
);

   localparam int DEPTH   = ROWS * PLANES * lmbf_pkg::PIX_WORDS;
   localparam int PLANE_W = $clog2(PLANES);
   localparam int GW      = lmbf_pkg::GAMMA_W;

   logic                          clearing_ff, clearing_in;
   logic [ADDR_W-1:0]             clr_addr_ff, clr_addr_in;
   logic                          active_ff, active_in;
   logic [PLANE_W-1:0]            plane_ff, plane_in;
   logic [GW-1:0]                 red_sh_ff, red_sh_in;
   logic [GW-1:0]                 green_sh_ff, green_sh_in;
   logic [GW-1:0]                 blue_sh_ff, blue_sh_in;
   logic [ADDR_W-1:0]             addr_ff, addr_in;
   logic [lmbf_pkg::NIB_SEL_W-1:0] nib_ff, nib_in;
   logic                          in_range;
   logic [lmbf_pkg::COL_W-1:0]    col;
   logic [3:0]                    nibble;

   assign in_range = (x < lmbf_pkg::COORD_W'(COLUMNS)) && (y < lmbf_pkg::COORD_W'(ROWS));
   // Column x lands on mirrored position COLUMNS-1-x of the row.
   assign col      = lmbf_pkg::COL_W'(COLUMNS - 1) - x[lmbf_pkg::COL_W-1:0];
   // Nibble layout: dummy, red, blue, green from bit 0 upward.
   assign nibble   = {green_sh_ff[0], blue_sh_ff[0], red_sh_ff[0], 1'b0};

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      active_in   = active_ff;
      plane_in    = plane_ff;
      red_sh_in   = red_sh_ff;
      green_sh_in = green_sh_ff;
      blue_sh_in  = blue_sh_ff;
      addr_in     = addr_ff;
      nib_in      = nib_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
      if (active_ff) begin
         red_sh_in   = red_sh_ff >> 1;
         green_sh_in = green_sh_ff >> 1;
         blue_sh_in  = blue_sh_ff >> 1;
         addr_in     = addr_ff + ADDR_W'(lmbf_pkg::PIX_WORDS);
         plane_in    = plane_ff + 1'b1;
         if (plane_ff == PLANE_W'(PLANES - 1)) begin
            active_in = 1'b0;
         end
      end else if (start && in_range) begin
         active_in   = 1'b1;
         plane_in    = '0;
         red_sh_in   = lmbf_pkg::RED_GAMMA_ROM[red * GW +: GW];
         green_sh_in = lmbf_pkg::GREEN_GAMMA_ROM[green * GW +: GW];
         blue_sh_in  = lmbf_pkg::BLUE_GAMMA_ROM[blue * GW +: GW];
         addr_in     = ADDR_W'(y[lmbf_pkg::ROW_W-1:0])
                       * ADDR_W'(PLANES * lmbf_pkg::PIX_WORDS)
                       + ADDR_W'(col[lmbf_pkg::COL_W-1]);
         nib_in      = col[lmbf_pkg::NIB_SEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
         active_ff   <= 1'b0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
         active_ff   <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      plane_ff    <= plane_in;
      red_sh_ff   <= red_sh_in;
      green_sh_ff <= green_sh_in;
      blue_sh_ff  <= blue_sh_in;
      addr_ff     <= addr_in;
      nib_ff      <= nib_in;
   end

   always_comb begin
      if (clearing_ff) begin
         wr_addr   = clr_addr_ff;
         wr.en     = 1'b1;
         wr.nib_en = '1;
         wr.data   = '0;
      end else begin
         wr_addr   = addr_ff;
         wr.en     = active_ff;
         wr.nib_en = lmbf_pkg::NIBBLES'(1) << nib_ff;
         wr.data   = {lmbf_pkg::NIBBLES{nibble}};
      end
   end

   assign busy = clearing_ff || active_ff;

endmodule

FILE: hw/rtl/lmbf_stream.sv
// ----------------------------------------------------------------------------
// lmbf_stream
// Walks the display stream word by word: pixel words from the plane memory,
// control words built from the row and frame counters.
// ----------------------------------------------------------------------------
module lmbf_stream #(
   parameter int ROWS   = lmbf_pkg::ROWS_DEFAULT,
   parameter int PLANES = lmbf_pkg::PLANES_DEFAULT,
   parameter int ADDR_W = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [lmbf_pkg::WORD_W-1:0]       rd_data,
   input  logic                              rsp_stall,
   output logic                              rd_en,
   output logic [ADDR_W-1:0]                 rd_addr,
   output logic                              busy,
   output logic                              rsp_valid,
   output logic [lmbf_pkg::WORD_W-1:0]       rsp_word,
   output logic                              rsp_last
);

   localparam int FRAME_W = $clog2(PLANES);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LOAD = 1'b1;

   localparam logic [1:0] POS_PIX0 = 2'd0;
   localparam logic [1:0] POS_PIX1 = 2'd1;
   localparam logic [1:0] POS_CTRL = 2'd2;

   logic                          state_ff, state_in;
   logic [1:0]                    pos_ff, pos_in;
   logic [FRAME_W-1:0]            frame_ff, frame_in;
   logic [lmbf_pkg::ROW_W-1:0]    row_ff, row_in;
   logic [ADDR_W-1:0]             pix_addr_ff, pix_addr_in;
   logic                          valid_ff, valid_in;
   logic [lmbf_pkg::WORD_W-1:0]   word_ff, word_in;
   logic                          last_ff, last_in;
   logic                          load;
   logic                          discharge;
   logic                          final_frame_row;
   logic [7:0]                    select;
   logic [15:0]                   ticks;

   assign discharge       = (frame_ff == FRAME_W'(PLANES - 1));
   assign final_frame_row = discharge && (row_ff == lmbf_pkg::ROW_W'(ROWS - 1));
   assign select          = discharge ? lmbf_pkg::DISCHARGE_SELECT : ~(8'h80 >> row_ff);
   assign ticks           = discharge ? lmbf_pkg::DISCHARGE_TICKS : (16'd1 << frame_ff);

   // The output register may still hold an untaken result; wait for it.
   assign load = (state_ff == ST_LOAD) && (!valid_ff || !rsp_stall);

   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      frame_in    = frame_ff;
      row_in      = row_ff;
      pix_addr_in = pix_addr_ff;
      valid_in    = valid_ff && rsp_stall;
      word_in     = word_ff;
      last_in     = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (load) begin
               state_in = ST_IDLE;
               valid_in = 1'b1;
               last_in  = 1'b0;
               if (pos_ff == POS_CTRL) begin
                  word_in = {8'h00, ticks, select};
                  pos_in  = POS_PIX0;
                  if (discharge) begin
                     frame_in = '0;
                     if (final_frame_row) begin
                        last_in     = 1'b1;
                        row_in      = '0;
                        pix_addr_in = '0;
                     end else begin
                        row_in = row_ff + 1'b1;
                     end
                  end else begin
                     frame_in = frame_ff + 1'b1;
                  end
               end else begin
                  word_in     = rd_data;
                  pos_in      = (pos_ff == POS_PIX0) ? POS_PIX1 : POS_CTRL;
                  pix_addr_in = pix_addr_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pos_ff      <= POS_PIX0;
         frame_ff    <= '0;
         row_ff      <= '0;
         pix_addr_ff <= '0;
         valid_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pos_ff      <= pos_in;
         frame_ff    <= frame_in;
         row_ff      <= row_in;
         pix_addr_ff <= pix_addr_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      last_ff <= last_in;
   end

   // The read address is ready before the request, so the read goes out
   // on the transfer itself.
   assign rd_en     = start;
   assign rd_addr   = pix_addr_ff;
   assign busy      = (state_ff == ST_LOAD);
   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;
   assign rsp_last  = last_ff;

endmodule

FILE: hw/rtl/led_matrix_bitplane_framebuffer.sv
// ----------------------------------------------------------------------------
// led_matrix_bitplane_framebuffer
// Bit-plane frame buffer for an RGB LED matrix driven by binary code
// modulation: gamma-corrected pixel writes and a 32-bit display stream.
// ----------------------------------------------------------------------------
//   channel   direction  handshake               payload
//   req       in         req_valid / req_stall   kind, x, y, red, green, blue
//   rsp       out        rsp_valid / rsp_stall   word, last
//
// A pixel write holds the request side after its transfer while it writes each
// plane in turn, one plane-memory write per cycle through the single write port,
// so the next write waits until the last plane is written. A fetch reads the
// memory on its transfer, then loads the output register; it waits in that load
// step, with req_stall high, while an earlier result is stalled. After reset
// the plane memory is cleared with req_stall high.
// ----------------------------------------------------------------------------
module led_matrix_bitplane_framebuffer #(
   parameter int ROWS    = lmbf_pkg::ROWS_DEFAULT,
   parameter int PLANES  = lmbf_pkg::PLANES_DEFAULT,
   parameter int COLUMNS = lmbf_pkg::COLUMNS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_kind,
   input  logic [lmbf_pkg::COORD_W-1:0]      req_x,
   input  logic [lmbf_pkg::COORD_W-1:0]      req_y,
   input  logic [lmbf_pkg::COLOR_W-1:0]      req_red,
   input  logic [lmbf_pkg::COLOR_W-1:0]      req_green,
   input  logic [lmbf_pkg::COLOR_W-1:0]      req_blue,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [lmbf_pkg::WORD_W-1:0]       rsp_word,
   output logic                              rsp_last
);

   localparam int DEPTH  = ROWS * PLANES * lmbf_pkg::PIX_WORDS;
   localparam int ADDR_W = $clog2(DEPTH);

   logic                          accept;
   logic                          write_start;
   logic                          fetch_start;
   logic                          writer_busy;
   logic                          stream_busy;
   logic [ADDR_W-1:0]             wr_addr;
   lmbf_pkg::wr_port_type         wr;
   logic                          rd_en;
   logic [ADDR_W-1:0]             rd_addr;
   logic [lmbf_pkg::WORD_W-1:0]   rd_data;

   assign req_stall   = writer_busy || stream_busy;
   assign accept      = req_valid && !req_stall;
   assign write_start = accept && (req_kind == lmbf_pkg::KIND_PIXEL);
   assign fetch_start = accept && (req_kind == lmbf_pkg::KIND_FETCH);

   lmbf_pixel_writer #(
      .ROWS    (ROWS),
      .PLANES  (PLANES),
      .COLUMNS (COLUMNS),
      .ADDR_W  (ADDR_W)
   ) u_writer (
      .clock   (clock),
      .reset   (reset),
      .start   (write_start),
      .x       (req_x),
      .y       (req_y),
      .red     (req_red),
      .green   (req_green),
      .blue    (req_blue),
      .busy    (writer_busy),
      .wr_addr (wr_addr),
      .wr      (wr)
   );

   lmbf_plane_ram #(
      .DEPTH   (DEPTH),
      .ADDR_W  (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_addr (wr_addr),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lmbf_stream #(
      .ROWS    (ROWS),
      .PLANES  (PLANES),
      .ADDR_W  (ADDR_W)
   ) u_stream (
      .clock     (clock),
      .reset     (reset),
      .start     (fetch_start),
      .rd_data   (rd_data),
      .rsp_stall (rsp_stall),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .busy      (stream_busy),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .rsp_last  (rsp_last)
   );

endmodule

FILE: hw/rtl/lmbf_checker.sv
// ----------------------------------------------------------------------------
// lmbf_checker
// Port-level checks for the LED matrix bit-plane frame buffer.
// ----------------------------------------------------------------------------
module lmbf_checker #(
   parameter int ROWS    = lmbf_pkg::ROWS_DEFAULT,
   parameter int COLUMNS = lmbf_pkg::COLUMNS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic                              req_kind,
   input  logic [lmbf_pkg::COORD_W-1:0]      req_x,
   input  logic [lmbf_pkg::COORD_W-1:0]      req_y,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [lmbf_pkg::WORD_W-1:0]       rsp_word,
   input  logic                              rsp_last
);

   // Reset leaves no result behind and starts the clearing pass.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_stall))
      else $error("result pending or requests open right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result dropped");

   // A fetch always occupies the block for the cycle after its transfer.
   a_fetch_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_kind == lmbf_pkg::KIND_FETCH) |=> req_stall)
      else $error("request taken during a fetch");

   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_kind == lmbf_pkg::KIND_PIXEL
       && req_x < lmbf_pkg::COORD_W'(COLUMNS) && req_y < lmbf_pkg::COORD_W'(ROWS))
      |=> req_stall)
      else $error("request taken during a pixel write");

   // The final word is always the control word of a discharge frame.
   a_last_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last)
      |-> (rsp_word[31:24] == 8'h00 && rsp_word[7:0] == lmbf_pkg::DISCHARGE_SELECT
           && rsp_word[23:8] == lmbf_pkg::DISCHARGE_TICKS))
      else $error("last word is not a discharge control word");

endmodule

bind led_matrix_bitplane_framebuffer lmbf_checker #(
   .ROWS    (ROWS),
   .COLUMNS (COLUMNS)
) u_checker (.*);
